// ----- hw/rtl/matrix_multiply_accumulate_macros.svh -----
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_macros
// assertion macros for the matrix multiply-accumulate block
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

`ifndef ASSERT_OFF
`define MMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MMA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define MMA_ASSERT(lbl, prop, msg)
`define MMA_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ----- hw/rtl/mma_pkg.sv -----
// ----------------------------------------------------------------------------
// mma_pkg
// types, constants and codes shared by the matrix multiply-accumulate block
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int MAX_N  = 8;
  localparam int IDX_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int DATA_W = 64;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_LOAD_C = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_SIZE     = 2'd0,
    CFG_ROW_BASE = 2'd1,
    CFG_COL_BASE = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_WR,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  typedef struct packed {
    cmd_e               command;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [63:0] value;
  } mma_in_t;

  typedef struct packed {
    logic [3:0]         out_row;
    logic [3:0]         out_col;
    logic signed [63:0] out_value;
    logic               last;
  } mma_out_t;

  // one classified word between front and back
  typedef struct packed {
    logic              valid;
    cmd_e              op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
  } mma_op_t;

  typedef struct packed {
    logic [3:0] size;
    logic [2:0] row_base;
    logic [2:0] col_base;
  } mma_cfg_t;

endpackage

// ----- hw/rtl/mma_front.sv -----
// ----------------------------------------------------------------------------
// mma_front
// accepts input words, drops out-of-range loads, queues the rest for the back
// ----------------------------------------------------------------------------
module mma_front import mma_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  output logic    full_o,
  input  mma_in_t in_data_i,
  output mma_op_t op_o,
  input  logic    op_take_i
);

  mma_op_t    q_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, in_range, enq, deq;
  mma_op_t    word;

  assign full_o = (cnt_q == 2'd2);
  assign accept = push_i && !full_o;

  always_comb begin
    in_range = ({1'b0, in_data_i.row} < 4'(MAX_N)) && ({1'b0, in_data_i.col} < 4'(MAX_N));
    word.valid = 1'b1;
    word.op    = in_data_i.command;
    word.addr  = {in_data_i.row[IDX_W-1:0], in_data_i.col[IDX_W-1:0]};
    word.value = in_data_i.value;
  end

  assign enq = accept && (in_range || in_data_i.command == CMD_RUN);
  assign deq = op_take_i && (cnt_q != 2'd0);

  always_comb begin
    cnt_d = cnt_q;
    if (enq && !deq) begin
      cnt_d = cnt_q + 2'd1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (enq) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_q[wr_ptr_q] <= word;
    end
  end

  always_comb begin
    op_o       = q_q[rd_ptr_q];
    op_o.valid = (cnt_q != 2'd0);
  end

endmodule

// ----- hw/rtl/mma_mac.sv -----
// ----------------------------------------------------------------------------
// mma_mac
// 64-bit wrapping multiply-add from 32x32 partial products, one register stage
// ----------------------------------------------------------------------------
module mma_mac import mma_pkg::*; (
  input  logic              clk_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  input  logic [DATA_W-1:0] c_i,
  output logic [DATA_W-1:0] sum_o
);

  logic [63:0] p_ll_q;
  logic [31:0] p_lh_q, p_hl_q;
  logic [63:0] c_q;
  logic [31:0] p_lh, p_hl;

  // only the low halves of the cross products reach the 64-bit result
  assign p_lh = a_i[31:0] * b_i[63:32];
  assign p_hl = a_i[63:32] * b_i[31:0];

  always_ff @(posedge clk_i) begin
    p_ll_q <= a_i[31:0] * b_i[31:0];
    p_lh_q <= p_lh;
    p_hl_q <= p_hl;
    c_q    <= c_i;
  end

  assign sum_o = c_q + p_ll_q + {p_lh_q + p_hl_q, 32'd0};

endmodule

// ----- hw/rtl/mma_back.sv -----
// ----------------------------------------------------------------------------
// mma_back
// operand and accumulator stores, i-k-j sequencer and result queue
// ----------------------------------------------------------------------------
`include "matrix_multiply_accumulate_macros.svh"

module mma_back import mma_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mma_cfg_t cfg_i,
  input  mma_op_t  op_i,
  output logic     op_take_o,
  output logic     empty_o,
  input  logic     pop_i,
  output mma_out_t out_data_o
);

  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];
  logic [DATA_W-1:0] c_mem [DEPTH];
  logic [DEPTH-1:0]  c_vld_q;

  state_e state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, k_q, k_d, j_q, j_d, nm1_q, nm1_d;
  logic [DATA_W-1:0] a_rd_q, b_rd_q, c_rd_q, mac_sum, c_val;
  logic              c_rd_vld_q;
  logic [ADDR_W-1:0] c_addr;
  logic              rd_en, mac_wr, ld_wr, res_push;
  logic [IDX_W-1:0]  nm1_run;
  logic [3:0]        size_m1;

  mma_out_t   res_q [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;
  logic       res_pop;
  mma_out_t   res_word;

  // clamp size into 1..MAX_N, kept as n-1
  always_comb begin
    if (cfg_i.size == 4'd0) begin
      size_m1 = 4'd0;
    end else if (cfg_i.size > 4'(MAX_N)) begin
      size_m1 = 4'(MAX_N - 1);
    end else begin
      size_m1 = cfg_i.size - 4'd1;
    end
    nm1_run = size_m1[IDX_W-1:0];
  end

  assign c_addr = {i_q, j_q};
  assign c_val  = c_rd_vld_q ? c_rd_q : '0;

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    k_d       = k_q;
    j_d       = j_q;
    nm1_d     = nm1_q;
    op_take_o = 1'b0;
    ld_wr     = 1'b0;
    rd_en     = 1'b0;
    mac_wr    = 1'b0;
    res_push  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (op_i.valid) begin
          op_take_o = 1'b1;
          if (op_i.op == CMD_RUN) begin
            nm1_d   = nm1_run;
            i_d     = '0;
            k_d     = '0;
            j_d     = '0;
            state_d = ST_MAC_RD;
          end else begin
            ld_wr = 1'b1;
          end
        end
      end
      ST_MAC_RD: begin
        rd_en   = 1'b1;
        state_d = ST_MAC_MUL;
      end
      ST_MAC_MUL: begin
        state_d = ST_MAC_WR;
      end
      ST_MAC_WR: begin
        mac_wr  = 1'b1;
        state_d = ST_MAC_RD;
        if (j_q != nm1_q) begin
          j_d = j_q + IDX_W'(1);
        end else begin
          j_d = '0;
          if (k_q != nm1_q) begin
            k_d = k_q + IDX_W'(1);
          end else begin
            k_d = '0;
            if (i_q != nm1_q) begin
              i_d = i_q + IDX_W'(1);
            end else begin
              i_d     = '0;
              state_d = ST_EMIT_RD;
            end
          end
        end
      end
      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (res_cnt_q != 2'd2) begin
          res_push = 1'b1;
          state_d  = ST_EMIT_RD;
          if (j_q != nm1_q) begin
            j_d = j_q + IDX_W'(1);
          end else begin
            j_d = '0;
            if (i_q != nm1_q) begin
              i_d = i_q + IDX_W'(1);
            end else begin
              i_d     = '0;
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      k_q     <= '0;
      j_q     <= '0;
      nm1_q   <= '0;
      c_vld_q <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      k_q     <= k_d;
      j_q     <= j_d;
      nm1_q   <= nm1_d;
      if (ld_wr && op_i.op == CMD_LOAD_C) begin
        c_vld_q[op_i.addr] <= 1'b1;
      end else if (mac_wr) begin
        c_vld_q[c_addr] <= 1'b1;
      end
    end
  end

  // stores: one write and one registered read per cycle each
  always_ff @(posedge clk_i) begin
    if (ld_wr && op_i.op == CMD_LOAD_A) begin
      a_mem[op_i.addr] <= op_i.value;
    end
    if (rd_en) begin
      a_rd_q <= a_mem[{i_q, k_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_wr && op_i.op == CMD_LOAD_B) begin
      b_mem[op_i.addr] <= op_i.value;
    end
    if (rd_en) begin
      b_rd_q <= b_mem[{k_q, j_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_wr && op_i.op == CMD_LOAD_C) begin
      c_mem[op_i.addr] <= op_i.value;
    end else if (mac_wr) begin
      c_mem[c_addr] <= mac_sum;
    end
    if (rd_en) begin
      c_rd_q     <= c_mem[c_addr];
      c_rd_vld_q <= c_vld_q[c_addr];
    end
  end

  mma_mac u_mac (
    .clk_i (clk_i),
    .a_i   (a_rd_q),
    .b_i   (b_rd_q),
    .c_i   (c_val),
    .sum_o (mac_sum)
  );

  // result queue
  always_comb begin
    res_word.out_row   = {1'b0, cfg_i.row_base} + 4'(i_q);
    res_word.out_col   = {1'b0, cfg_i.col_base} + 4'(j_q);
    res_word.out_value = c_val;
    res_word.last      = (i_q == nm1_q) && (j_q == nm1_q);
  end

  assign empty_o    = (res_cnt_q == 2'd0);
  assign res_pop    = pop_i && !empty_o;
  assign out_data_o = res_q[res_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
    end else begin
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
      if (res_push) begin
        res_wr_q <= !res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= !res_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q] <= res_word;
    end
  end

  `MMA_ASSERT_NEVER(a_res_overflow, res_cnt_q == 2'd3, "result queue count out of range")
  `MMA_ASSERT(a_size_held, !$stable(nm1_q) |-> $past(state_q) == ST_IDLE, "size changed in a run")
  `MMA_ASSERT(a_mac_follows_mul, mac_wr |-> $past(state_q) == ST_MAC_MUL, "accumulator out of order")
  `MMA_ASSERT_NEVER(a_take_busy, op_take_o && state_q != ST_IDLE, "command taken while busy")

endmodule

// ----- hw/rtl/matrix_multiply_accumulate.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// square matrix multiply-accumulate, C += A * B, with element loads and emit
// ----------------------------------------------------------------------------
// A load word (A, B or C element) is taken from the head of the two-word
// command queue while the sequencer is idle. A start word runs the i-k-j
// product on a single 64-bit MAC built from 32x32 partial products: each of
// the n*n*n steps passes through store read, multiply and accumulate write,
// then the n*n results are emitted, each read from the store and written to
// the result queue, which holds the emit back while it is full. Results leave
// through a two-word queue; A and B hold anything until written, C starts at zero.
module matrix_multiply_accumulate import mma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  mma_in_t    in_data_i,
  output logic       empty_o,
  input  logic       pop_i,
  output mma_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i
);

  mma_cfg_t cfg_q;
  mma_op_t  op;
  logic     op_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size     <= 4'd8;
      cfg_q.row_base <= 3'd0;
      cfg_q.col_base <= 3'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_e'(cfg_index_i))
        CFG_SIZE:     cfg_q.size     <= cfg_data_i;
        CFG_ROW_BASE: cfg_q.row_base <= cfg_data_i[2:0];
        CFG_COL_BASE: cfg_q.col_base <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  mma_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .in_data_i (in_data_i),
    .op_o      (op),
    .op_take_i (op_take)
  );

  mma_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_i       (op),
    .op_take_o  (op_take),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- bench/mma_checker.sv -----
// ----------------------------------------------------------------------------
// mma_checker
// watches the load, result and register channels of the multiply-accumulate
// block, keeps its own copy of the element stores and registers, predicts
// every emitted word and compares it field by field with what comes out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_checker import mma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_o,
  input  mma_in_t    in_data_i,
  input  logic       empty_o,
  input  logic       pop_i,
  input  mma_out_t   out_data_o,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [3:0] cfg_data_i,
  output int         errors_o,
  output int         pending_o
);

  logic [63:0] a_mat [MAX_N][MAX_N];
  logic [63:0] b_mat [MAX_N][MAX_N];
  logic [63:0] c_mat [MAX_N][MAX_N];
  logic [3:0]  size_q;
  logic [2:0]  row_base_q;
  logic [2:0]  col_base_q;
  mma_out_t    block_q [$];

  task automatic report(string field, mma_out_t got, mma_out_t want);
    $display("%s mismatch at %0t: got %0d/%0d %h %b, want %0d/%0d %h %b",
             field, $time, got.out_row, got.out_col, got.out_value, got.last,
             want.out_row, want.out_col, want.out_value, want.last);
    errors_o++;
  endtask

  // C += A*B over the leading n x n block, then queue the block row-major
  task automatic accumulate_block();
    int n;
    mma_out_t w;
    n = (size_q == 0) ? 1 : (size_q > MAX_N) ? MAX_N : int'(size_q);
    for (int i = 0; i < n; i++)
      for (int k = 0; k < n; k++)
        for (int j = 0; j < n; j++)
          c_mat[i][j] = c_mat[i][j] + a_mat[i][k] * b_mat[k][j];
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        w.out_row   = 4'(row_base_q) + 4'(i);
        w.out_col   = 4'(col_base_q) + 4'(j);
        w.out_value = c_mat[i][j];
        w.last      = (i == n - 1) && (j == n - 1);
        block_q.push_back(w);
      end
  endtask

  task automatic check_word(mma_out_t got);
    mma_out_t want;
    if (block_q.size() == 0) begin
      report("unexpected word", got, got);
    end else begin
      want = block_q.pop_front();
      if (got.out_row != want.out_row) report("out_row", got, want);
      if (got.out_col != want.out_col) report("out_col", got, want);
      if (got.out_value != want.out_value) report("out_value", got, want);
      if (got.last != want.last) report("last", got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_N; i++)
        for (int j = 0; j < MAX_N; j++) c_mat[i][j] = '0;
      size_q     = 4'd8;
      row_base_q = '0;
      col_base_q = '0;
      block_q.delete();
      errors_o   = 0;
      pending_o  = 0;
    end else begin
      if (pop_i && !empty_o) check_word(out_data_o);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_e'(cfg_index_i))
          CFG_SIZE:     size_q = cfg_data_i;
          CFG_ROW_BASE: row_base_q = cfg_data_i[2:0];
          CFG_COL_BASE: col_base_q = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (push_i && !full_o) begin
        // 3-bit indexes always fall inside the stores
        case (in_data_i.command)
          CMD_LOAD_A: a_mat[in_data_i.row][in_data_i.col] = in_data_i.value;
          CMD_LOAD_B: b_mat[in_data_i.row][in_data_i.col] = in_data_i.value;
          CMD_LOAD_C: c_mat[in_data_i.row][in_data_i.col] = in_data_i.value;
          default:    accumulate_block();
        endcase
      end
      pending_o = block_q.size();
    end
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// drives element loads, start words and register writes into the
// multiply-accumulate block with bursty input and a stalling result side;
// the checker predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mma_pkg::*;

  localparam int IDLE_LIMIT = 10000;
  localparam int SETTLE_CYC = 20;

  logic       clk_i;
  logic       rst_ni;
  logic       push_i;
  logic       full_o;
  mma_in_t    in_data_i;
  logic       empty_o;
  logic       pop_i;
  mma_out_t   out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [3:0] cfg_data_i;
  int         errors;
  int         pending;

  logic [63:0] a_set;
  logic [63:0] b_set;
  logic [3:0]  size_raw;
  int          burst_left;
  int          words_sent;
  int          idle_cyc;
  int          stall_left;
  int          cyc;

  matrix_multiply_accumulate u_top (
    .clk_i, .rst_ni, .push_i, .full_o, .in_data_i, .empty_o, .pop_i,
    .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  mma_checker u_check (
    .clk_i, .rst_ni, .push_i, .full_o, .in_data_i, .empty_o, .pop_i,
    .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // result side: calm stretches alternate with busy ones full of stalls
  always @(negedge clk_i) begin
    cyc++;
    if (stall_left > 0) begin
      pop_i <= 1'b0;
      stall_left--;
    end else begin
      pop_i <= 1'b1;
      if ((cyc / 600) % 2 == 1 && $urandom_range(0, 3) == 0)
        stall_left = $urandom_range(1, 12);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o))
        idle_cyc = 0;
      else
        idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("matrix_multiply_accumulate verification failed");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(0, 40)) - 20);
      2: begin
        case ($urandom_range(0, 3))
          0: return 64'h7fff_ffff_ffff_ffff;
          1: return 64'h8000_0000_0000_0000;
          2: return '1;
          default: return '0;
        endcase
      end
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  function automatic int active_n();
    return (size_raw == 0) ? 1 : (size_raw > MAX_N) ? MAX_N : int'(size_raw);
  endfunction

  task automatic put_word(cmd_e cmd, int r, int c, logic [63:0] v);
    if (burst_left == 0) begin
      @(negedge clk_i) push_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    @(negedge clk_i);
    push_i <= 1'b1;
    in_data_i <= '{command: cmd, row: 3'(r), col: 3'(c), value: v};
    do @(posedge clk_i); while (full_o);
    burst_left--;
    words_sent++;
    if (cmd == CMD_LOAD_A) a_set[r * MAX_N + c] = 1'b1;
    if (cmd == CMD_LOAD_B) b_set[r * MAX_N + c] = 1'b1;
  endtask

  // drain every expected word, then let queued loads finish
  task automatic settle();
    @(negedge clk_i) push_i <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [3:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
    if (idx == CFG_SIZE) size_raw = d;
  endtask

  // every operand read by the block must have been written first
  task automatic run_block();
    int n;
    n = active_n();
    for (int i = 0; i < n; i++)
      for (int k = 0; k < n; k++) begin
        if (!a_set[i * MAX_N + k]) put_word(CMD_LOAD_A, i, k, rand_value());
        if (!b_set[i * MAX_N + k]) put_word(CMD_LOAD_B, i, k, rand_value());
      end
    put_word(CMD_RUN, $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
  endtask

  initial begin
    int pick;
    rst_ni      = 1'b0;
    push_i      = 1'b0;
    pop_i       = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SIZE;
    cfg_data_i  = '0;
    a_set       = '0;
    b_set       = '0;
    size_raw    = 4'd8;
    burst_left  = 0;
    words_sent  = 0;
    idle_cyc    = 0;
    stall_left  = 0;
    cyc         = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // size zero acts as one, bases at their top, an out-of-range index
    write_reg(CFG_SIZE, 4'd0);
    write_reg(CFG_ROW_BASE, 4'd7);
    write_reg(CFG_COL_BASE, 4'd7);
    write_reg(CFG_NONE, 4'hf);
    put_word(CMD_LOAD_A, 0, 0, 64'h7fff_ffff_ffff_ffff);
    put_word(CMD_LOAD_B, 0, 0, 64'h8000_0000_0000_0000);
    put_word(CMD_LOAD_C, 0, 0, '1);
    put_word(CMD_LOAD_C, 7, 7, 64'h7fff_ffff_ffff_ffff);
    run_block();
    put_word(CMD_LOAD_A, 0, 0, 64'h8000_0000_0000_0000);
    put_word(CMD_LOAD_B, 0, 0, '1);
    run_block();
    run_block();
    settle();
    write_reg(CFG_SIZE, 4'd2);
    put_word(CMD_LOAD_A, 1, 1, '1);
    put_word(CMD_LOAD_B, 1, 0, 64'h7fff_ffff_ffff_ffff);
    run_block();
    settle();
    // oversize clamps to the full matrix
    write_reg(CFG_SIZE, 4'hf);
    write_reg(CFG_ROW_BASE, 4'd0);
    write_reg(CFG_COL_BASE, 4'd0);
    run_block();
    settle();
    write_reg(CFG_SIZE, 4'd8);
    write_reg(CFG_ROW_BASE, 4'd3);
    write_reg(CFG_COL_BASE, 4'd5);
    put_word(CMD_LOAD_C, 7, 0, 64'h8000_0000_0000_0000);
    run_block();

    while (words_sent < 430) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        pick = $urandom_range(0, 19);
        if (pick < 12)      write_reg(CFG_SIZE, 4'($urandom_range(1, 4)));
        else if (pick < 15) write_reg(CFG_SIZE, 4'($urandom_range(5, 7)));
        else if (pick == 15) write_reg(CFG_SIZE, 4'd8);
        else if (pick == 16) write_reg(CFG_SIZE, 4'd0);
        else if (pick == 17) write_reg(CFG_SIZE, 4'($urandom_range(9, 15)));
        if ($urandom_range(0, 1)) write_reg(CFG_ROW_BASE, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 1)) write_reg(CFG_COL_BASE, 4'($urandom_range(0, 15)));
        if ($urandom_range(0, 4) == 0) write_reg(CFG_NONE, 4'($urandom_range(0, 15)));
      end
      repeat ($urandom_range(0, 8))
        put_word(cmd_e'($urandom_range(0, 2)), $urandom_range(0, 7),
                 $urandom_range(0, 7), rand_value());
      run_block();
      if ($urandom_range(0, 9) == 0) run_block();
    end

    @(negedge clk_i) push_i <= 1'b0;
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("matrix_multiply_accumulate verification clean");
    else
      $display("matrix_multiply_accumulate verification failed");
    $finish;
  end

endmodule

// ----- matrix_multiply_accumulate.f -----
+incdir+hw/rtl
hw/rtl/mma_pkg.sv
hw/rtl/mma_front.sv
hw/rtl/mma_mac.sv
hw/rtl/mma_back.sv
hw/rtl/matrix_multiply_accumulate.sv
bench/mma_checker.sv
bench/testbench.sv
